// File: design/rotating_stereo_panner_top_macros.svh
// ----------------------------------------------------------------------------
// Rotating stereo panner assertion macros
// Shared property shorthands, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ROTATING_STEREO_PANNER_TOP_MACROS_SVH
`define ROTATING_STEREO_PANNER_TOP_MACROS_SVH

// a holds at an edge, so b must hold at the same edge
`define RSP_ASSERT_IMPL(label, a, b) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error("rotating_stereo_panner_top: same-cycle check failed");

// a holds at an edge, so b must hold at the next edge
`define RSP_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error("rotating_stereo_panner_top: next-cycle check failed");

`endif

// File: design/rsp_pkg.sv
// ----------------------------------------------------------------------------
// rsp_pkg
// Shared types and constants of the rotating stereo panner.
// ----------------------------------------------------------------------------
package rsp_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_PHASE = 2'd0,
    CFG_PHASE_STEP  = 2'd1
  } cfg_idx_e;

  // pi/2 in Q2.30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [14:0] Q15_MAX     = 15'h7fff;

  // per-channel control that travels with the table addresses
  typedef struct packed {
    logic full_l;  // quarter boundary: value is the peak, not a table entry
    logic neg_l;
    logic full_r;
    logic neg_r;
  } sine_ctrl_t;

endpackage

// File: design/rsp_phase.sv
// ----------------------------------------------------------------------------
// rsp_phase
// Phase accumulator and sine table address generation for both channels.
// ----------------------------------------------------------------------------
module rsp_phase #(
  parameter int unsigned PHASE_BITS     = 32,
  parameter int unsigned SINE_ADDR_BITS = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rsp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rsp_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              accept_i,   // request taken this cycle
  input  logic                              load_i,     // stage 0 advances
  output logic [SINE_ADDR_BITS-1:0]         addr_l_o,
  output logic [SINE_ADDR_BITS-1:0]         addr_r_o,
  output rsp_pkg::sine_ctrl_t               ctrl_o
);
  import rsp_pkg::*;

  localparam int unsigned TOP_W  = SINE_ADDR_BITS + 2;
  localparam int unsigned WIDE_W = PHASE_BITS + CFG_DATA_W;
  localparam int unsigned ANG_W  = PHASE_BITS + TOP_W;
  localparam logic [PHASE_BITS-1:0] EIGHTH = PHASE_BITS'(1) << (PHASE_BITS - 3);

  logic [PHASE_BITS-1:0]     acc_q, acc_d;
  logic [PHASE_BITS-1:0]     step_q, step_d;
  logic [WIDE_W-1:0]         wdata_wide;
  logic [PHASE_BITS-1:0]     wdata_al;
  logic [PHASE_BITS-1:0]     ang_l, ang_r;
  logic [ANG_W-1:0]          ang_l_wide, ang_r_wide;
  logic [TOP_W-1:0]          top_l, top_r;
  logic [SINE_ADDR_BITS-1:0] idx_l, idx_r;
  logic [SINE_ADDR_BITS-1:0] addr_l_d, addr_r_d;
  logic [SINE_ADDR_BITS-1:0] addr_l_q, addr_r_q;
  sine_ctrl_t                ctrl_d, ctrl_q;

  // 2^32 on the register scale maps to the accumulator's full range
  assign wdata_wide = {cfg_wdata_i, {PHASE_BITS{1'b0}}};
  assign wdata_al   = wdata_wide[WIDE_W-1 -: PHASE_BITS];

  always_comb begin
    acc_d  = acc_q;
    step_d = step_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_START_PHASE: acc_d  = wdata_al;
        CFG_PHASE_STEP:  step_d = wdata_al;
        default: ;
      endcase
    end else if (accept_i) begin
      acc_d = acc_q + step_q;
    end
  end

  // quantize each angle to quadrant plus quarter-wave index
  assign ang_l      = acc_q - EIGHTH;
  assign ang_r      = acc_q + EIGHTH;
  assign ang_l_wide = {ang_l, {TOP_W{1'b0}}};
  assign ang_r_wide = {ang_r, {TOP_W{1'b0}}};
  assign top_l      = ang_l_wide[ANG_W-1 -: TOP_W];
  assign top_r      = ang_r_wide[ANG_W-1 -: TOP_W];
  assign idx_l      = top_l[SINE_ADDR_BITS-1:0];
  assign idx_r      = top_r[SINE_ADDR_BITS-1:0];

  // odd quadrants read the table mirrored
  assign addr_l_d = top_l[SINE_ADDR_BITS] ? (~idx_l + SINE_ADDR_BITS'(1)) : idx_l;
  assign addr_r_d = top_r[SINE_ADDR_BITS] ? (~idx_r + SINE_ADDR_BITS'(1)) : idx_r;

  always_comb begin
    ctrl_d.full_l = top_l[SINE_ADDR_BITS] && (idx_l == '0);
    ctrl_d.neg_l  = !top_l[TOP_W-1];  // left channel uses the negated sine
    ctrl_d.full_r = top_r[SINE_ADDR_BITS] && (idx_r == '0);
    ctrl_d.neg_r  = top_r[TOP_W-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      step_q <= '0;
    end else begin
      acc_q  <= acc_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      addr_l_q <= addr_l_d;
      addr_r_q <= addr_r_d;
      ctrl_q   <= ctrl_d;
    end
  end

  assign addr_l_o = addr_l_q;
  assign addr_r_o = addr_r_q;
  assign ctrl_o   = ctrl_q;

endmodule

// File: design/rsp_sine_rom.sv
// ----------------------------------------------------------------------------
// rsp_sine_rom
// Quarter-wave Q1.15 sine table with two registered read ports and sign.
// ----------------------------------------------------------------------------
module rsp_sine_rom #(
  parameter int unsigned SINE_ADDR_BITS = 10
) (
  input  logic                      clk_i,
  input  logic                      load_i,
  input  logic [SINE_ADDR_BITS-1:0] addr_l_i,
  input  logic [SINE_ADDR_BITS-1:0] addr_r_i,
  input  rsp_pkg::sine_ctrl_t       ctrl_i,
  output logic signed [15:0]        sin_l_o,
  output logic signed [15:0]        sin_r_o
);
  import rsp_pkg::*;

  localparam int unsigned SINE_LEN = 1 << SINE_ADDR_BITS;
  localparam int unsigned TaylorDiv [6] = '{156, 110, 72, 42, 20, 6};

  typedef logic [14:0] sine_tab_t [SINE_LEN];

  // entry i = round(32768 * sin(i*pi/2/LEN)), capped at the Q1.15 peak
  function automatic sine_tab_t build_tab();
    sine_tab_t   tab;
    logic [63:0] one;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] v;
    one = 64'd1 << 30;
    for (int i = 0; i < SINE_LEN; i++) begin
      x  = (HALF_PI_Q30 * 64'(i)) >> SINE_ADDR_BITS;
      x2 = (x * x) >> 30;
      t  = one;
      for (int k = 0; k < 6; k++) begin
        t = one - (((x2 * t) >> 30) / 64'(TaylorDiv[k]));
      end
      v = (x * t) >> 30;
      v = (v + 64'd16384) >> 15;
      tab[i] = (v > 64'd32767) ? Q15_MAX : v[14:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_tab();

  logic [14:0]        mag_l, mag_r;
  logic signed [15:0] sin_l_q, sin_r_q;

  assign mag_l = ctrl_i.full_l ? Q15_MAX : SINE_TAB[addr_l_i];
  assign mag_r = ctrl_i.full_r ? Q15_MAX : SINE_TAB[addr_r_i];

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sin_l_q <= ctrl_i.neg_l ? -$signed({1'b0, mag_l}) : $signed({1'b0, mag_l});
      sin_r_q <= ctrl_i.neg_r ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
    end
  end

  assign sin_l_o = sin_l_q;
  assign sin_r_o = sin_r_q;

endmodule

// File: design/rsp_scale.sv
// ----------------------------------------------------------------------------
// rsp_scale
// Gain multiply, then round half up and saturate one channel to the sample range.
// ----------------------------------------------------------------------------
module rsp_scale #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          mul_load_i,
  input  logic                          out_load_i,
  input  logic signed [SAMPLE_BITS:0]   sum_i,
  input  logic signed [15:0]            gain_i,
  output logic signed [SAMPLE_BITS-1:0] sample_o
);
  localparam int unsigned PROD_W = SAMPLE_BITS + 17;
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [PROD_W-1:0]      prod_q;
  logic signed [PROD_W-1:0]      rnd;
  logic signed [SAMPLE_BITS:0]   shr;
  logic signed [SAMPLE_BITS-1:0] sat_d, sat_q;

  always_ff @(posedge clk_i) begin
    if (mul_load_i) begin
      prod_q <= PROD_W'(sum_i) * PROD_W'(gain_i);
    end
  end

  assign rnd = prod_q + PROD_W'(32768);
  assign shr = rnd[SAMPLE_BITS+16:16];

  // top two bits disagree: result left the sample range
  always_comb begin
    if (shr[SAMPLE_BITS] == shr[SAMPLE_BITS-1]) begin
      sat_d = shr[SAMPLE_BITS-1:0];
    end else if (shr[SAMPLE_BITS]) begin
      sat_d = SMP_MIN;
    end else begin
      sat_d = SMP_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load_i) begin
      sat_q <= sat_d;
    end
  end

  assign sample_o = sat_q;

endmodule

// File: design/rotating_stereo_panner_top.sv
// ----------------------------------------------------------------------------
// rotating_stereo_panner_top
// Sine-law auto panner: mono sum scaled by two phase-shifted sines.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                     content
//  s_axis    in   s_axis_tvalid/s_axis_tready   left_in, right_in
//  m_axis    out  m_axis_tvalid/m_axis_tready   left_out, right_out
//  cfg       in   cfg_we_i                      start_phase, phase_step
//
//  One request per cycle while s_axis_tready is high; each result passes the
//  address register, sine table read, multiplier and round/saturate register.
//  Every stage advances when the stage after it is empty or advancing, so
//  a stalled output fills the pipe before s_axis_tready drops.
//  Reset clears the valid bits, the accumulator and the step; no table init.
// ----------------------------------------------------------------------------
`include "rotating_stereo_panner_top_macros.svh"

module rotating_stereo_panner_top #(
  parameter int unsigned SAMPLE_BITS    = 24,
  parameter int unsigned PHASE_BITS     = 32,
  parameter int unsigned SINE_ADDR_BITS = 10,
  localparam int unsigned TDATA_W       = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rsp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rsp_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [TDATA_W-1:0]             s_axis_tdata,  // left_in, right_in
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [TDATA_W-1:0]             m_axis_tdata   // left_out, right_out
);
  import rsp_pkg::*;

  logic v0_q, v1_q, v2_q, v3_q;
  logic adv0, adv1, adv2, adv3;
  logic accept;

  logic signed [SAMPLE_BITS-1:0] left_in, right_in;
  logic signed [SAMPLE_BITS:0]   sum_d, sum0_q, sum1_q;

  logic [SINE_ADDR_BITS-1:0] addr_l, addr_r;
  sine_ctrl_t                ctrl;
  logic signed [15:0]        sin_l, sin_r;
  logic signed [SAMPLE_BITS-1:0] left_out, right_out;

  assign adv3   = !v3_q || m_axis_tready;
  assign adv2   = !v2_q || adv3;
  assign adv1   = !v1_q || adv2;
  assign adv0   = !v0_q || adv1;
  assign accept = s_axis_tvalid && adv0;

  assign s_axis_tready = adv0;
  assign m_axis_tvalid = v3_q;

  assign left_in  = s_axis_tdata[SAMPLE_BITS-1:0];
  assign right_in = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign sum_d    = {left_in[SAMPLE_BITS-1], left_in} + {right_in[SAMPLE_BITS-1], right_in};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv0) v0_q <= s_axis_tvalid;
      if (adv1) v1_q <= v0_q;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  // hold the channel sum alongside the sine lookup
  always_ff @(posedge clk_i) begin
    if (adv0) sum0_q <= sum_d;
    if (adv1) sum1_q <= sum0_q;
  end

  rsp_phase #(
    .PHASE_BITS     (PHASE_BITS),
    .SINE_ADDR_BITS (SINE_ADDR_BITS)
  ) u_phase (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .load_i      (adv0),
    .addr_l_o    (addr_l),
    .addr_r_o    (addr_r),
    .ctrl_o      (ctrl)
  );

  rsp_sine_rom #(
    .SINE_ADDR_BITS (SINE_ADDR_BITS)
  ) u_sine (
    .clk_i    (clk_i),
    .load_i   (adv1),
    .addr_l_i (addr_l),
    .addr_r_i (addr_r),
    .ctrl_i   (ctrl),
    .sin_l_o  (sin_l),
    .sin_r_o  (sin_r)
  );

  rsp_scale #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scale_l (
    .clk_i      (clk_i),
    .mul_load_i (adv2),
    .out_load_i (adv3),
    .sum_i      (sum1_q),
    .gain_i     (sin_l),
    .sample_o   (left_out)
  );

  rsp_scale #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scale_r (
    .clk_i      (clk_i),
    .mul_load_i (adv2),
    .out_load_i (adv3),
    .sum_i      (sum1_q),
    .gain_i     (sin_r),
    .sample_o   (right_out)
  );

  assign m_axis_tdata = TDATA_W'({right_out, left_out});

  // input stalls only when every stage is full and the output is blocked
  `RSP_ASSERT_IMPL(a_stall_only_when_full, !s_axis_tready, v0_q && v1_q && v2_q && v3_q && !m_axis_tready)
  // a result appears only if the multiplier stage held an item
  `RSP_ASSERT_IMPL(a_out_from_mul, $rose(m_axis_tvalid), $past(v2_q))
  // a taken result with nothing behind it leaves the output empty
  `RSP_ASSERT_NEXT(a_drain, m_axis_tvalid && m_axis_tready && !v2_q, !m_axis_tvalid)

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rotating stereo panner. A scoreboard keeps its
// own phase accumulator and quarter-wave sine table, predicts both panned
// channels for every accepted request and compares each returned sample.
// Directed extremes and a full phase turn come first, then random traffic
// under several pan settings, idle patterns and a long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  import rsp_pkg::*;

  localparam int unsigned SAMPLE_BITS    = 24;
  localparam int unsigned PHASE_BITS     = 32;
  localparam int unsigned SINE_ADDR_BITS = 10;
  localparam int unsigned TDATA_W        = ((2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned SINE_LEN       = 1 << SINE_ADDR_BITS;

  localparam logic [PHASE_BITS-1:0] EIGHTH_TURN = {3'b001, {(PHASE_BITS - 3){1'b0}}};
  localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN = -(longint'(1) << (SAMPLE_BITS - 1));
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;
  localparam int unsigned TAYLOR_DIV [6] = '{156, 110, 72, 42, 20, 6};

  localparam int PIPE_LAT       = 4;
  localparam int DRAIN_CYCLES   = 4 * PIPE_LAT;
  localparam int HOLD_CYCLES    = 300;
  localparam int BATCH_ITEMS    = 45;
  localparam int BUSY_IDLE_PCT  = 86;
  localparam int LIGHT_IDLE_PCT = 17;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] right;
    logic signed [SAMPLE_BITS-1:0] left;
  } stereo_t;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  class pan_scoreboard;
    logic [14:0]           sine_rom [SINE_LEN];
    logic [PHASE_BITS-1:0] phase_acc;
    logic [31:0]           phase_inc;
    stereo_t               pan_expect_q[$];
    int                    errors;

    function new();
      logic [63:0] x, x2, t, v;
      // quarter-wave table from a fixed-point Taylor series in Q2.30
      for (int i = 0; i < SINE_LEN; i++) begin
        x  = (HALF_PI_Q30 * i) >> SINE_ADDR_BITS;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        for (int k = 0; k < 6; k++) t = Q30_ONE - ((x2 * t) >> 30) / TAYLOR_DIV[k];
        v = (((x * t) >> 30) + 64'd16384) >> 15;
        sine_rom[i] = (v > Q15_MAX) ? Q15_MAX : v[14:0];
      end
      phase_acc = '0;
      phase_inc = '0;
      errors    = 0;
    endfunction

    function int sine_at(logic [PHASE_BITS-1:0] ang);
      logic [1:0]                quad;
      logic [SINE_ADDR_BITS-1:0] idx;
      int                        mag;
      quad = ang[PHASE_BITS-1 -: 2];
      idx  = ang[PHASE_BITS-3 -: SINE_ADDR_BITS];
      if (!quad[0]) begin
        mag = sine_rom[idx];
      end else if (idx == 0) begin
        mag = Q15_MAX;  // quarter boundary lands on the peak itself
      end else begin
        mag = sine_rom[SINE_LEN - idx];
      end
      return quad[1] ? -mag : mag;
    endfunction

    function logic [SAMPLE_BITS-1:0] scale_sat(longint sum, int gain);
      longint prod;
      prod = (sum * gain + 32768) >>> 16;
      if (prod > SAMPLE_MAX) prod = SAMPLE_MAX;
      if (prod < SAMPLE_MIN) prod = SAMPLE_MIN;
      return prod[SAMPLE_BITS-1:0];
    endfunction

    function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_START_PHASE: phase_acc = val;
        CFG_PHASE_STEP:  phase_inc = val;
        default: ;
      endcase
    endfunction

    function void note_sample(stereo_t smp);
      longint  sum;
      stereo_t pan;
      sum = $signed(smp.left);
      sum += $signed(smp.right);
      // output uses the phase before this sample's step
      pan.left  = scale_sat(sum, -sine_at(phase_acc - EIGHTH_TURN));
      pan.right = scale_sat(sum, sine_at(phase_acc + EIGHTH_TURN));
      pan_expect_q.push_back(pan);
      phase_acc += phase_inc;
    endfunction

    function void check_result(stereo_t got);
      stereo_t want;
      if (pan_expect_q.size() == 0) begin
        $error("m_axis: result %h with no request outstanding", got);
        errors++;
        return;
      end
      want = pan_expect_q.pop_front();
      if (got.left !== want.left) begin
        $error("left_out: expected %0d, got %0d", want.left, got.left);
        errors++;
      end
      if (got.right !== want.right) begin
        $error("right_out: expected %0d, got %0d", want.right, got.right);
        errors++;
      end
    endfunction

    function int pending();
      return pan_expect_q.size();
    endfunction
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [TDATA_W-1:0]    s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]    m_axis_tdata;

  pan_scoreboard score;
  stereo_t       stim_q[$];
  idle_mode_e    idle_mode = IDLE_NONE;
  bit            hold_req  = 1'b0;
  bit            hold_seen = 1'b0;
  int            stall_left = 0;
  int unsigned   cycle_cnt  = 0;

  rotating_stereo_panner_top #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .PHASE_BITS    (PHASE_BITS),
    .SINE_ADDR_BITS(SINE_ADDR_BITS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // monitors and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) score.configure(cfg_idx_i, cfg_wdata_i);
      if (s_axis_tvalid && s_axis_tready) score.note_sample(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) score.check_result(m_axis_tdata);
    end
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // output ready: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen  = hold_req;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !((idle_mode == IDLE_RECV && $urandom_range(99) < BUSY_IDLE_PCT) ||
                         (idle_mode == IDLE_BOTH && $urandom_range(99) < LIGHT_IDLE_PCT));
    end
  end

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(7))
      0: return SAMPLE_MAX[SAMPLE_BITS-1:0];
      1: return SAMPLE_MIN[SAMPLE_BITS-1:0];
      2: return SAMPLE_BITS'($urandom_range(255));
      3: return -SAMPLE_BITS'($urandom_range(255));
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic void queue_sample(longint l, longint r);
    stereo_t smp;
    smp.left  = l[SAMPLE_BITS-1:0];
    smp.right = r[SAMPLE_BITS-1:0];
    stim_q.push_back(smp);
  endfunction

  function automatic void fill_random(int n);
    stereo_t smp;
    for (int i = 0; i < n; i++) begin
      smp.left  = pick_sample();
      smp.right = pick_sample();
      stim_q.push_back(smp);
    end
  endfunction

  task automatic play_samples();
    stereo_t smp;
    while (stim_q.size() != 0) begin
      smp = stim_q.pop_front();
      while ((idle_mode == IDLE_SEND && $urandom_range(99) < BUSY_IDLE_PCT) ||
             (idle_mode == IDLE_BOTH && $urandom_range(99) < LIGHT_IDLE_PCT)) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= smp;
      do @(posedge clk_i); while (!s_axis_tready);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // hold until every request has come back, then let the pipe settle
  task automatic wait_idle();
    @(posedge clk_i);
    while (score.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // optional phase reload, then the step, then junk to the unused indexes
  task automatic load_pan(input bit reload, input logic [31:0] pan_pos,
                          input logic [31:0] pan_rate);
    if (reload) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= CFG_START_PHASE;
      cfg_wdata_i <= pan_pos;
      @(posedge clk_i);
    end
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_PHASE_STEP;
    cfg_wdata_i <= pan_rate;
    @(posedge clk_i);
    for (int k = CFG_PHASE_STEP + 1; k < (1 << CFG_IDX_W); k++) begin
      cfg_idx_i   <= CFG_IDX_W'(k);
      cfg_wdata_i <= $urandom;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    score = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full-scale and tiny sums at a fixed pan position
    load_pan(1'b1, '0, '0);
    queue_sample(SAMPLE_MAX, SAMPLE_MAX);
    queue_sample(SAMPLE_MIN, SAMPLE_MIN);
    queue_sample(SAMPLE_MAX, SAMPLE_MIN);
    queue_sample(SAMPLE_MIN, SAMPLE_MAX);
    queue_sample(0, 0);
    queue_sample(1, 0);
    queue_sample(-1, -1);
    queue_sample(SAMPLE_MAX, 0);
    play_samples();
    wait_idle();

    // one full turn in sixteenths: hits every quadrant edge and the peak
    load_pan(1'b1, '0, 32'h1000_0000);
    for (int i = 0; i < 16; i++) begin
      if (i % 2 == 0) queue_sample(SAMPLE_MAX, SAMPLE_MAX);
      else queue_sample(SAMPLE_MIN, SAMPLE_MIN);
    end
    play_samples();
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      idle_mode = idle_mode_e'(ph % 4);
      case (ph)
        0: load_pan(1'b1, '1, 32'h8000_0000);
        1: load_pan(1'b1, $urandom, 32'h7fff_ffff);
        2: load_pan(1'b0, '0, '1);  // keep the running phase, step back by one
        3: load_pan(1'b1, $urandom, 32'd1);
        4: load_pan(1'b0, '0, -32'($urandom_range(1 << 20)));
        default: load_pan(1'b1, $urandom, $urandom);
      endcase
      fill_random(BATCH_ITEMS);
      play_samples();
      wait_idle();
    end

    // hold the output long enough for the pipe to fill and back up the input
    idle_mode = IDLE_NONE;
    load_pan(1'b1, $urandom, $urandom);
    hold_req <= ~hold_req;
    fill_random(40);
    play_samples();
    wait_idle();

    if (score.errors == 0 && score.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/rsp_pkg.sv
design/rsp_phase.sv
design/rsp_sine_rom.sv
design/rsp_scale.sv
design/rotating_stereo_panner_top.sv
sim/tb.sv
